// ----- sv/mbep_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the escape-time pixel block.
// Used by the multiply unit, the datapath, the controller and the top level.
package mbep_pkg;

  localparam int WORD_W    = 64;
  localparam int SHIFT_W   = 48;
  localparam int COLOR_W   = 8;
  localparam int REG_IDX_W = 2;

  localparam int FRAC_BITS_DEF        = 58;
  localparam int ITER_BITS_DEF        = 16;
  localparam int PIXEL_COORD_BITS_DEF = 12;

  typedef logic signed [WORD_W-1:0] word_t;

  localparam word_t WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

  // Configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_SHIFT_X    = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_SHIFT_Y    = REG_IDX_W'(1);
  localparam logic [REG_IDX_W-1:0] REG_PIXEL_STEP = REG_IDX_W'(2);
  localparam logic [REG_IDX_W-1:0] REG_MAX_ITER   = REG_IDX_W'(3);

  localparam logic [WORD_W-1:0] RST_SHIFT_X    = 64'd640;
  localparam logic [WORD_W-1:0] RST_SHIFT_Y    = 64'd360;
  localparam logic [WORD_W-1:0] RST_PIXEL_STEP = 64'd960767920505639;
  localparam logic [31:0]       RST_MAX_ITER   = 32'd100;

  // Write data is as wide as the widest configuration register
  function automatic int cfg_width(input int frac_bits, input int iter_bits);
    int w;
    w = SHIFT_W;
    if (frac_bits > w) w = frac_bits;
    if (iter_bits > w) w = iter_bits;
    return w;
  endfunction

  typedef struct packed {
    logic load_pixel;
    logic mul_start;
    logic mul_c;
    logic load_c;
    logic sums;
    logic update;
    logic div_start;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic finish;
  } status_t;

endpackage

// ----- sv/mbep_mul.sv -----
`timescale 1ns / 1ps
// Signed 64x64 saturating fixed-point multiplier built on one 32x32 multiplier.
// Four partial products, then an optional shift by FRAC_BITS (truncating toward zero) and saturation. Uses mbep_pkg.
module mbep_mul #(
  parameter int FRAC_BITS = mbep_pkg::FRAC_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic            shift_frac,
  input  mbep_pkg::word_t a,
  input  mbep_pkg::word_t b,
  output logic            done,
  output mbep_pkg::word_t p
);
  import mbep_pkg::*;

  localparam int HALF_W = WORD_W / 2;
  localparam int PROD_W = 2 * WORD_W;

  logic              busy;
  logic [2:0]        cnt;
  logic [WORD_W-1:0] ma;
  logic [WORD_W-1:0] mb;
  logic              neg;
  logic              sh;
  logic [HALF_W-1:0] a_half;
  logic [HALF_W-1:0] b_half;
  logic [WORD_W-1:0] pp;
  logic [1:0]        pp_idx;
  logic [PROD_W-1:0] acc;
  logic [PROD_W-1:0] pp_ext;
  logic [PROD_W-1:0] shifted;
  logic [WORD_W-1:0] m;
  logic              over;
  word_t             sat;

  always_comb begin
    a_half  = cnt[1] ? ma[WORD_W-1:HALF_W] : ma[HALF_W-1:0];
    b_half  = cnt[0] ? mb[WORD_W-1:HALF_W] : mb[HALF_W-1:0];
    pp_ext  = {{WORD_W{1'b0}}, pp} << (HALF_W * (32'(pp_idx[1]) + 32'(pp_idx[0])));
    shifted = sh ? (acc >> FRAC_BITS) : acc;
    over    = |shifted[PROD_W-1:WORD_W];
    m       = shifted[WORD_W-1:0];
    if (!neg) begin
      sat = (over || m[WORD_W-1]) ? WORD_MAX : word_t'(m);
    end else begin
      sat = (over || (m[WORD_W-1] && |m[WORD_W-2:0])) ? WORD_MIN
                                                      : word_t'((~m) + WORD_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 3'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 3'd0;
      end else if (busy) begin
        if (cnt == 3'd5) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ma  <= a[WORD_W-1] ? WORD_W'(-a) : WORD_W'(a);
      mb  <= b[WORD_W-1] ? WORD_W'(-b) : WORD_W'(b);
      neg <= a[WORD_W-1] ^ b[WORD_W-1];
      sh  <= shift_frac;
      acc <= '0;
    end else if (busy) begin
      if (cnt <= 3'd3) begin
        pp     <= WORD_W'(a_half) * WORD_W'(b_half);
        pp_idx <= cnt[1:0];
      end
      // accumulate the partial product registered in the previous cycle
      if (cnt >= 3'd1 && cnt <= 3'd4) acc <= acc + pp_ext;
      if (cnt == 3'd5) p <= sat;
    end
  end

endmodule

// ----- sv/mbep_div.sv -----
`timescale 1ns / 1ps
// Restoring unsigned divider, one quotient bit per cycle.
// Standalone; no package dependencies.
module mbep_div #(
  parameter int NUM_W = 26,
  parameter int DEN_W = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W:0]   rem;
  logic [DEN_W-1:0] d;
  logic [DEN_W:0]   trial;
  logic             fits;

  always_comb begin
    trial = {rem[DEN_W-1:0], quo[NUM_W-1]};
    fits  = trial >= {1'b0, d};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= num;
      rem <= '0;
      d   <= den;
    end else if (busy) begin
      rem <= fits ? (trial - {1'b0, d}) : trial;
      quo <= {quo[NUM_W-2:0], fits};
    end
  end

endmodule

// ----- sv/mbep_datapath.sv -----
`timescale 1ns / 1ps
// Datapath: configuration registers, pixel mapping, z iteration, color bands.
// Uses mbep_pkg, three mbep_mul units and one mbep_div.
module mbep_datapath #(
  parameter int FRAC_BITS        = mbep_pkg::FRAC_BITS_DEF,
  parameter int ITER_BITS        = mbep_pkg::ITER_BITS_DEF,
  parameter int PIXEL_COORD_BITS = mbep_pkg::PIXEL_COORD_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  mbep_pkg::cmd_t                         cmd,
  output mbep_pkg::status_t                      status,
  input  logic [PIXEL_COORD_BITS-1:0]            column,
  input  logic [PIXEL_COORD_BITS-1:0]            row,
  input  logic                                   write_enable,
  input  logic [mbep_pkg::REG_IDX_W-1:0]         write_index,
  input  logic [mbep_pkg::cfg_width(FRAC_BITS, ITER_BITS)-1:0] write_data,
  output logic                                   painted,
  output logic [mbep_pkg::COLOR_W-1:0]           red,
  output logic [mbep_pkg::COLOR_W-1:0]           green,
  output logic [mbep_pkg::COLOR_W-1:0]           blue,
  output logic [ITER_BITS-1:0]                   iteration_count
);
  import mbep_pkg::*;

  localparam int K_RED   = 1020;
  localparam int K_GREEN = 510;
  localparam int K_BLUE  = 255;
  localparam int K_W     = $clog2(K_RED + 1);
  localparam int NUM_W   = ITER_BITS + K_W;

  localparam logic [1:0] BAND_NONE  = 2'd0;
  localparam logic [1:0] BAND_RED   = 2'd1;
  localparam logic [1:0] BAND_GREEN = 2'd2;
  localparam logic [1:0] BAND_BLUE  = 2'd3;

  localparam word_t LIMIT4 = word_t'(WORD_W'(4) << FRAC_BITS);

  function automatic word_t sat_add(input word_t x, input word_t y);
    word_t s;
    s = x + y;
    if (!x[WORD_W-1] && !y[WORD_W-1] && s[WORD_W-1]) return WORD_MAX;
    if (x[WORD_W-1] && y[WORD_W-1] && !s[WORD_W-1]) return WORD_MIN;
    return s;
  endfunction

  function automatic word_t sat_sub(input word_t x, input word_t y);
    word_t s;
    s = x - y;
    if (!x[WORD_W-1] && y[WORD_W-1] && s[WORD_W-1]) return WORD_MAX;
    if (x[WORD_W-1] && !y[WORD_W-1] && !s[WORD_W-1]) return WORD_MIN;
    return s;
  endfunction

  logic [SHIFT_W-1:0]   shift_x;
  logic [SHIFT_W-1:0]   shift_y;
  logic [FRAC_BITS-1:0] pixel_step;
  logic [ITER_BITS-1:0] max_iterations;

  word_t dx, dy, cr, ci, zr, zi, diff, dbl;
  word_t step_w;
  word_t mul_a0, mul_b0, mul_a1, mul_b1;
  word_t prod0, prod1, prod2;
  logic  done0, done1, done2;
  logic  escaped;

  logic [ITER_BITS-1:0] n;
  logic [ITER_BITS+1:0] n_w;
  logic [ITER_BITS+1:0] lim_w;
  logic [1:0]           band;
  logic [1:0]           band_sel;
  logic [K_W-1:0]       k_sel;
  logic [NUM_W-1:0]     num;
  logic [NUM_W-1:0]     quo;
  logic                 div_done;
  logic [COLOR_W-1:0]   red_c, green_c, blue_c;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      shift_x        <= RST_SHIFT_X[SHIFT_W-1:0];
      shift_y        <= RST_SHIFT_Y[SHIFT_W-1:0];
      pixel_step     <= RST_PIXEL_STEP[FRAC_BITS-1:0];
      max_iterations <= RST_MAX_ITER[ITER_BITS-1:0];
    end else if (write_enable) begin
      unique case (write_index)
        REG_SHIFT_X:    shift_x        <= write_data[SHIFT_W-1:0];
        REG_SHIFT_Y:    shift_y        <= write_data[SHIFT_W-1:0];
        REG_PIXEL_STEP: pixel_step     <= write_data[FRAC_BITS-1:0];
        REG_MAX_ITER:   max_iterations <= write_data[ITER_BITS-1:0];
      endcase
    end
  end

  always_comb begin
    step_w = word_t'({{(WORD_W-FRAC_BITS){1'b0}}, pixel_step});
    mul_a0 = cmd.mul_c ? dx : zr;
    mul_b0 = cmd.mul_c ? step_w : zr;
    mul_a1 = cmd.mul_c ? dy : zi;
    mul_b1 = cmd.mul_c ? step_w : zi;
  end

  // prod0 = zr*zr, prod1 = zi*zi, prod2 = zr*zi in the iteration;
  // prod0/prod1 = cr/ci while mapping the pixel
  mbep_mul #(.FRAC_BITS(FRAC_BITS)) u_mul0 (
    .clk(clk), .rst(rst), .start(cmd.mul_start), .shift_frac(!cmd.mul_c),
    .a(mul_a0), .b(mul_b0), .done(done0), .p(prod0)
  );

  mbep_mul #(.FRAC_BITS(FRAC_BITS)) u_mul1 (
    .clk(clk), .rst(rst), .start(cmd.mul_start), .shift_frac(!cmd.mul_c),
    .a(mul_a1), .b(mul_b1), .done(done1), .p(prod1)
  );

  mbep_mul #(.FRAC_BITS(FRAC_BITS)) u_mul2 (
    .clk(clk), .rst(rst), .start(cmd.mul_start), .shift_frac(!cmd.mul_c),
    .a(zr), .b(zi), .done(done2), .p(prod2)
  );

  // Band select against the limit
  always_comb begin
    n_w   = {2'b00, n};
    lim_w = {2'b00, max_iterations};
    if ((n_w << 2) < lim_w) begin
      band_sel = BAND_RED;
      k_sel    = K_W'(K_RED);
    end else if ((n_w << 1) < lim_w) begin
      band_sel = BAND_GREEN;
      k_sel    = K_W'(K_GREEN);
    end else if (n_w < lim_w) begin
      band_sel = BAND_BLUE;
      k_sel    = K_W'(K_BLUE);
    end else begin
      band_sel = BAND_NONE;
      k_sel    = '0;
    end
    num = NUM_W'(n) * NUM_W'(k_sel);
  end

  mbep_div #(.NUM_W(NUM_W), .DEN_W(ITER_BITS)) u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start), .num(num), .den(max_iterations),
    .done(div_done), .quo(quo)
  );

  always_comb begin
    red_c   = '0;
    green_c = '0;
    blue_c  = '0;
    unique case (band)
      BAND_NONE:  ;
      BAND_RED:   red_c   = quo[COLOR_W-1:0];
      BAND_GREEN: green_c = quo[COLOR_W-1:0];
      BAND_BLUE:  blue_c  = quo[COLOR_W-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load_pixel) begin
      dx <= word_t'({{(WORD_W-PIXEL_COORD_BITS){1'b0}}, column})
          - word_t'({{(WORD_W-SHIFT_W){shift_x[SHIFT_W-1]}}, shift_x});
      dy <= word_t'({{(WORD_W-PIXEL_COORD_BITS){1'b0}}, row})
          - word_t'({{(WORD_W-SHIFT_W){shift_y[SHIFT_W-1]}}, shift_y});
      n  <= '0;
    end
    if (cmd.load_c) begin
      cr <= prod0;
      ci <= prod1;
      zr <= prod0;
      zi <= prod1;
    end
    if (cmd.sums) begin
      diff    <= sat_sub(prod0, prod1);
      dbl     <= sat_add(prod2, prod2);
      escaped <= sat_add(prod0, prod1) > LIMIT4;
    end
    if (cmd.update) begin
      zr <= sat_add(diff, cr);
      zi <= sat_add(dbl, ci);
      n  <= n + ITER_BITS'(1);
    end
    if (rst) band <= BAND_NONE;
    else if (cmd.div_start) band <= band_sel;
    if (cmd.load_out) begin
      painted         <= band != BAND_NONE;
      red             <= red_c;
      green           <= green_c;
      blue            <= blue_c;
      iteration_count <= n;
    end
  end

  // The escape test does not apply to the squares of the starting point
  assign status.mul_done = done0 & done1 & done2;
  assign status.div_done = div_done;
  assign status.finish   = ((n != '0) && escaped) || (n >= max_iterations);

endmodule

// ----- sv/mbep_ctrl.sv -----
`timescale 1ns / 1ps
// Controller state machine: sequences mapping, iteration, coloring and output.
// Uses mbep_pkg command and status types.
module mbep_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              pixel_valid,
  output logic              pixel_stall,
  output logic              result_valid,
  input  logic              result_stall,
  output mbep_pkg::cmd_t    cmd,
  input  mbep_pkg::status_t status
);
  import mbep_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CSTART = 4'd1;
  localparam logic [3:0] S_CWAIT  = 4'd2;
  localparam logic [3:0] S_ZSTART = 4'd3;
  localparam logic [3:0] S_ZWAIT  = 4'd4;
  localparam logic [3:0] S_SUMS   = 4'd5;
  localparam logic [3:0] S_DECIDE = 4'd6;
  localparam logic [3:0] S_UPDATE = 4'd7;
  localparam logic [3:0] S_DSTART = 4'd8;
  localparam logic [3:0] S_DWAIT  = 4'd9;
  localparam logic [3:0] S_OUT    = 4'd10;

  logic [3:0] state;
  logic [3:0] state_next;

  assign pixel_stall = state != S_IDLE;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (pixel_valid) begin
          cmd.load_pixel = 1'b1;
          state_next     = S_CSTART;
        end
      end
      S_CSTART: begin
        cmd.mul_start = 1'b1;
        cmd.mul_c     = 1'b1;
        state_next    = S_CWAIT;
      end
      S_CWAIT: begin
        if (status.mul_done) begin
          cmd.load_c = 1'b1;
          state_next = S_ZSTART;
        end
      end
      S_ZSTART: begin
        cmd.mul_start = 1'b1;
        state_next    = S_ZWAIT;
      end
      S_ZWAIT: begin
        if (status.mul_done) state_next = S_SUMS;
      end
      S_SUMS: begin
        cmd.sums   = 1'b1;
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        state_next = status.finish ? S_DSTART : S_UPDATE;
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_next = S_ZSTART;
      end
      S_DSTART: begin
        cmd.div_start = 1'b1;
        state_next    = S_DWAIT;
      end
      S_DWAIT: begin
        if (status.div_done) state_next = S_OUT;
      end
      S_OUT: begin
        // hold until the output register is free
        if (!result_valid || !result_stall) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) result_valid <= 1'b1;
      else if (!result_stall) result_valid <= 1'b0;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !(result_valid && result_stall))
    else $error("result register loaded while a stalled request waits");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> result_valid)
    else $error("loaded result not presented");

  a_mul_done_wait: assert property (@(posedge clk) disable iff (rst)
    status.mul_done |-> (state == S_CWAIT || state == S_ZWAIT))
    else $error("multiply finished outside a wait state");

  a_div_done_wait: assert property (@(posedge clk) disable iff (rst)
    status.div_done |-> state == S_DWAIT)
    else $error("divide finished outside its wait state");

endmodule

// ----- sv/mandelbrot_escape_time_pixel.sv -----
`timescale 1ns / 1ps
// Escape-time pixel evaluator: maps a screen pixel to c and counts z = z^2 + c.
// Top level; uses mbep_pkg, mbep_ctrl and mbep_datapath.
//
// Usage:
//   Input channel (pixel_valid / pixel_stall, column, row): one request per pixel.
//   Output channel (result_valid / result_stall): painted, red, green, blue and
//   iteration_count for each pixel, in request order.
//   Configuration: write_enable with write_index 0..3 selects shift_x, shift_y,
//   pixel_step, max_iterations. Write only while no pixel is in flight.
// Operation:
//   Each iteration runs three 64x64 products in parallel, each through one 32x32
//   multiplier in four partial products; the color scale uses a one-bit-per-cycle
//   divider of ITER_BITS+10 steps. One pixel is worked on at a time. A new request
//   is taken as soon as the previous result sits in the output register, even if
//   it is still stalled.
// Reset (rst, synchronous): configuration returns to its defaults, any pixel in
//   flight is dropped and result_valid goes low.
// A stalled result holds its fields; the block waits before loading the next.
module mandelbrot_escape_time_pixel #(
  parameter int FRAC_BITS        = mbep_pkg::FRAC_BITS_DEF,
  parameter int ITER_BITS        = mbep_pkg::ITER_BITS_DEF,
  parameter int PIXEL_COORD_BITS = mbep_pkg::PIXEL_COORD_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   pixel_valid,
  output logic                                   pixel_stall,
  input  logic [PIXEL_COORD_BITS-1:0]            column,
  input  logic [PIXEL_COORD_BITS-1:0]            row,
  output logic                                   result_valid,
  input  logic                                   result_stall,
  output logic                                   painted,
  output logic [mbep_pkg::COLOR_W-1:0]           red,
  output logic [mbep_pkg::COLOR_W-1:0]           green,
  output logic [mbep_pkg::COLOR_W-1:0]           blue,
  output logic [ITER_BITS-1:0]                   iteration_count,
  input  logic                                   write_enable,
  input  logic [mbep_pkg::REG_IDX_W-1:0]         write_index,
  input  logic [mbep_pkg::cfg_width(FRAC_BITS, ITER_BITS)-1:0] write_data
);
  import mbep_pkg::*;

  cmd_t    cmd;
  status_t status;

  mbep_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .pixel_valid(pixel_valid),
    .pixel_stall(pixel_stall),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .cmd(cmd),
    .status(status)
  );

  mbep_datapath #(
    .FRAC_BITS(FRAC_BITS),
    .ITER_BITS(ITER_BITS),
    .PIXEL_COORD_BITS(PIXEL_COORD_BITS)
  ) u_datapath (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .status(status),
    .column(column),
    .row(row),
    .write_enable(write_enable),
    .write_index(write_index),
    .write_data(write_data),
    .painted(painted),
    .red(red),
    .green(green),
    .blue(blue),
    .iteration_count(iteration_count)
  );

endmodule
